/* sv/cbg_pkg.sv */
// Shared constants for the configuration button gesture detector.
// Holds register indexes, register reset values and field widths.
// No dependencies.
package cbg_pkg;

    // Width of every configuration register and of the write data.
    localparam int CFG_WIDTH = 16;
    // Width of the register index on the configuration port.
    localparam int CFG_IDX_WIDTH = 3;
    // Width of the reported gesture state.
    localparam int STATE_WIDTH = 3;
    // Default width of the elapsed-time counter.
    localparam int TIMER_WIDTH_DEF = 16;

    // Register indexes.
    localparam logic [CFG_IDX_WIDTH-1:0] REG_FIRST_LONG     = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SHORT_MIN      = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DEBOUNCE       = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SECOND_TIMEOUT = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SECOND_LONG    = 3'd4;

    // Register values after reset, in milliseconds.
    localparam logic [CFG_WIDTH-1:0] FIRST_LONG_RST     = 16'd5000;
    localparam logic [CFG_WIDTH-1:0] SHORT_MIN_RST      = 16'd100;
    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RST       = 16'd100;
    localparam logic [CFG_WIDTH-1:0] SECOND_TIMEOUT_RST = 16'd5000;
    localparam logic [CFG_WIDTH-1:0] SECOND_LONG_RST    = 16'd3000;

endpackage

/* sv/config_button_gesture_fsm_core.sv */
// Top level of the configuration button gesture detector.
// Holds the input stage, the gesture state machine, the result stage and the
// configuration registers. Depends on cbg_pkg.

// Each input item is one millisecond tick carrying the sampled button level;
// each item gives exactly one result item with the gesture state after the
// tick and one-tick request pulses for announce, link reset and factory reset.
// The block sustains one item per clock cycle while the output side is not
// stalled: an item is captured in an input register, and the state machine and
// elapsed-time counter update as it moves into the result register. The five
// millisecond thresholds are to be written through the configuration port
// while no item is in flight; the block itself does not enforce this. The
// elapsed counter is TIMER_WIDTH bits wide and saturates; a threshold that the
// counter cannot exceed makes the machine wait for the button instead.
module config_button_gesture_fsm_core #(
    parameter int TIMER_WIDTH = cbg_pkg::TIMER_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port
    input  logic                              cfg_write,
    input  logic [cbg_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [cbg_pkg::CFG_WIDTH-1:0]     cfg_data,
    // Input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              button_pressed,
    // Result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [cbg_pkg::STATE_WIDTH-1:0]   gesture_state,
    output logic                              announce_request,
    output logic                              link_reset_request,
    output logic                              factory_reset_request
);

    // Comparison width covers both the counter and the thresholds.
    localparam int CMP_WIDTH =
        (TIMER_WIDTH > cbg_pkg::CFG_WIDTH) ? TIMER_WIDTH : cbg_pkg::CFG_WIDTH;

    typedef enum logic [cbg_pkg::STATE_WIDTH-1:0] {
        ST_IDLE        = 3'd0,
        ST_FIRST       = 3'd1,
        ST_FIRST_LONG  = 3'd2,
        ST_WAIT_SECOND = 3'd3,
        ST_SECOND      = 3'd4,
        ST_SECOND_LONG = 3'd5
    } state_t;

    // Configuration registers.
    logic [cbg_pkg::CFG_WIDTH-1:0] first_long_reg;
    logic [cbg_pkg::CFG_WIDTH-1:0] short_min_reg;
    logic [cbg_pkg::CFG_WIDTH-1:0] debounce_reg;
    logic [cbg_pkg::CFG_WIDTH-1:0] second_timeout_reg;
    logic [cbg_pkg::CFG_WIDTH-1:0] second_long_reg;

    // Input stage.
    logic in_valid_reg;
    logic button_reg;

    // Gesture state and elapsed-time counter.
    state_t                 state_reg;
    state_t                 state_next;
    logic [TIMER_WIDTH-1:0] elapsed_reg;
    logic [TIMER_WIDTH-1:0] elapsed_next;

    // Result stage.
    logic out_valid_reg;
    state_t state_out_reg;
    logic announce_reg;
    logic announce_next;
    logic link_reg;
    logic link_next;
    logic factory_reg;
    logic factory_next;

    logic                   res_load;
    logic                   restart;
    logic [TIMER_WIDTH-1:0] elapsed_inc;
    logic [CMP_WIDTH-1:0]   e_cmp;
    logic                   gt_first_long;
    logic                   gt_short_min;
    logic                   lt_debounce;
    logic                   gt_second_timeout;
    logic                   gt_second_long;

    // Handshake: the item in the input stage moves on when the result stage
    // is empty or its item is being taken.
    assign res_load = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || res_load;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_long_reg     <= cbg_pkg::FIRST_LONG_RST;
            short_min_reg      <= cbg_pkg::SHORT_MIN_RST;
            debounce_reg       <= cbg_pkg::DEBOUNCE_RST;
            second_timeout_reg <= cbg_pkg::SECOND_TIMEOUT_RST;
            second_long_reg    <= cbg_pkg::SECOND_LONG_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                cbg_pkg::REG_FIRST_LONG:     first_long_reg     <= cfg_data;
                cbg_pkg::REG_SHORT_MIN:      short_min_reg      <= cfg_data;
                cbg_pkg::REG_DEBOUNCE:       debounce_reg       <= cfg_data;
                cbg_pkg::REG_SECOND_TIMEOUT: second_timeout_reg <= cfg_data;
                cbg_pkg::REG_SECOND_LONG:    second_long_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Saturating increment of the elapsed-time counter and the threshold tests.
    assign elapsed_inc = (elapsed_reg == {TIMER_WIDTH{1'b1}}) ?
                         elapsed_reg : elapsed_reg + TIMER_WIDTH'(1);
    assign e_cmp             = CMP_WIDTH'(elapsed_inc);
    assign gt_first_long     = e_cmp > CMP_WIDTH'(first_long_reg);
    assign gt_short_min      = e_cmp > CMP_WIDTH'(short_min_reg);
    assign lt_debounce       = e_cmp < CMP_WIDTH'(debounce_reg);
    assign gt_second_timeout = e_cmp > CMP_WIDTH'(second_timeout_reg);
    assign gt_second_long    = e_cmp > CMP_WIDTH'(second_long_reg);

    // Gesture decision for the item in the input stage.
    always_comb
    begin
        state_next    = state_reg;
        restart       = 1'b0;
        announce_next = 1'b0;
        link_next     = 1'b0;
        factory_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                restart = 1'b1;
                if (button_reg)
                begin
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                if (button_reg)
                begin
                    if (gt_first_long)
                    begin
                        state_next = ST_FIRST_LONG;
                    end
                end
                else
                begin
                    announce_next = gt_short_min;
                    state_next    = ST_IDLE;
                end
            end
            ST_FIRST_LONG:
            begin
                if (!button_reg)
                begin
                    state_next = ST_WAIT_SECOND;
                    restart    = 1'b1;
                    link_next  = 1'b1;
                end
            end
            ST_WAIT_SECOND:
            begin
                if (!lt_debounce)
                begin
                    if (button_reg)
                    begin
                        state_next = ST_SECOND;
                        restart    = 1'b1;
                    end
                    else if (gt_second_timeout)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SECOND:
            begin
                if (!lt_debounce)
                begin
                    if (button_reg)
                    begin
                        if (gt_second_long)
                        begin
                            state_next = ST_SECOND_LONG;
                        end
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SECOND_LONG:
            begin
                if (!button_reg)
                begin
                    factory_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        elapsed_next = restart ? '0 : elapsed_inc;
    end

    // Input stage, state machine and result stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            button_reg    <= 1'b0;
            state_reg     <= ST_IDLE;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
            state_out_reg <= ST_IDLE;
            announce_reg  <= 1'b0;
            link_reg      <= 1'b0;
            factory_reg   <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
                if (in_valid)
                begin
                    button_reg <= button_pressed;
                end
            end
            if (res_load)
            begin
                state_reg     <= state_next;
                elapsed_reg   <= elapsed_next;
                out_valid_reg <= 1'b1;
                state_out_reg <= state_next;
                announce_reg  <= announce_next;
                link_reg      <= link_next;
                factory_reg   <= factory_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid             = out_valid_reg;
    assign gesture_state         = state_out_reg;
    assign announce_request      = announce_reg;
    assign link_reset_request    = link_reg;
    assign factory_reset_request = factory_reg;

    // At most one request is raised by any item.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({announce_request, link_reset_request,
                                factory_reset_request}))
        else $error("more than one request raised by one item");

    // A link reset request always leaves the machine waiting for a second press.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && link_reset_request) |-> (gesture_state == ST_WAIT_SECOND))
        else $error("link reset request without entering wait second");

    // Announce and factory requests always return the machine to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (announce_request || factory_reset_request))
            |-> (gesture_state == ST_IDLE))
        else $error("announce or factory request without returning to idle");

    // An item processed in idle leaves the elapsed counter cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && (state_reg == ST_IDLE)) |=> (elapsed_reg == '0))
        else $error("elapsed counter not cleared after an idle item");

endmodule
